FILE: rtl/core/line_autokey_shift_cipher_defines.svh
// Assertion macros for the line autokey shift cipher.
`ifndef LINE_AUTOKEY_SHIFT_CIPHER_DEFINES_SVH
`define LINE_AUTOKEY_SHIFT_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that the consequent holds in the cycle in which the antecedent holds.
`define LAKC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Checks that an expression never holds.
`define LAKC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define LAKC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define LAKC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: rtl/core/lakc_pkg.sv
// Shared constants, types and symbol conversion functions of the line autokey shift cipher.
package lakc_pkg;

  localparam int MAX_LINE = 128;
  localparam int KEY_AW   = $clog2(MAX_LINE);
  localparam int LEN_W    = $clog2(MAX_LINE + 1);
  localparam int SYM_W    = 6;
  localparam int QDEPTH   = 3;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 2;

  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHR_DIG_0 = 8'h30;
  localparam logic [7:0] CHR_DIG_9 = 8'h39;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_COMMA = 8'h2C;

  localparam logic [SYM_W-1:0] SYM_LC_LAST  = 6'd25;
  localparam logic [SYM_W-1:0] SYM_UC_BASE  = 6'd26;
  localparam logic [SYM_W-1:0] SYM_UC_LAST  = 6'd51;
  localparam logic [SYM_W-1:0] SYM_DIG_BASE = 6'd52;
  localparam logic [SYM_W-1:0] SYM_DIG_LAST = 6'd61;
  localparam logic [SYM_W-1:0] SYM_SPACE    = 6'd62;
  localparam logic [SYM_W-1:0] SYM_COMMA    = 6'd63;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_EMPTY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       bad;
    logic       ovf;
  } result_t;

  typedef struct packed {
    logic              is_text;
    logic              is_empty;
    logic [SYM_W-1:0]  sym;
    logic              eol;
    logic              bad;
    logic              ovf;
    logic              wr_en;
    logic              wr_bank;
    logic [KEY_AW-1:0] wr_addr;
    logic              rd_bank;
    logic              key_zero;
    logic              fwd_hit;
    logic [SYM_W-1:0]  fwd_data;
  } s1_t;

  // Returns {bad, symbol}; a code outside the alphabet maps to symbol zero.
  function automatic logic [SYM_W:0] to_symbol(input logic [7:0] c);
    logic [7:0] d;
    logic       bad;
    bad = 1'b0;
    d   = '0;
    if (c >= CHR_LC_A && c <= CHR_LC_Z) begin
      d = c - CHR_LC_A;
    end else if (c >= CHR_UC_A && c <= CHR_UC_Z) begin
      d = c - CHR_UC_A + {2'b00, SYM_UC_BASE};
    end else if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
      d = c - CHR_DIG_0 + {2'b00, SYM_DIG_BASE};
    end else if (c == CHR_SPACE) begin
      d = {2'b00, SYM_SPACE};
    end else if (c == CHR_COMMA) begin
      d = {2'b00, SYM_COMMA};
    end else begin
      bad = 1'b1;
    end
    return {bad, d[SYM_W-1:0]};
  endfunction

  function automatic logic [7:0] to_char(input logic [SYM_W-1:0] s);
    logic [7:0] r;
    if (s <= SYM_LC_LAST) begin
      r = CHR_LC_A + {2'b00, s};
    end else if (s <= SYM_UC_LAST) begin
      r = CHR_UC_A + {2'b00, s - SYM_UC_BASE};
    end else if (s <= SYM_DIG_LAST) begin
      r = CHR_DIG_0 + {2'b00, s - SYM_DIG_BASE};
    end else if (s == SYM_SPACE) begin
      r = CHR_SPACE;
    end else begin
      r = CHR_COMMA;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/lakc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lakc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/line_autokey_shift_cipher.sv
// Top level of the line autokey shift cipher: key stores, control state and result queue.
// A result is registered first in the read stage and then in the queue before it can be taken.
// Throughput: one item per cycle while in_stall is low; the key RAM read of one cycle feeds the shift of the next.
// Results wait in a three-entry queue; input stalls once queue and read stage hold three items.
// Reset (synchronous, rst_n low) clears counters, bank select, load flag and the decrypt bit.
// The two key RAMs are not cleared; only entries below the key length are ever read.
`include "line_autokey_shift_cipher_defines.svh"

module line_autokey_shift_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_char,
  output logic       out_last_in_line,
  output logic       out_bad_symbol,
  output logic       out_line_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decrypt_mode
);

  // Control state. The store select bit names the bank that holds the current key;
  // the other bank collects the plaintext of the line in progress as the next key.
  logic                        decrypt_r;
  logic                        sel_r, sel_nxt;
  logic                        loading_r, loading_nxt;
  logic [lakc_pkg::LEN_W-1:0]  kl_r, kl_nxt;
  logic [lakc_pkg::LEN_W-1:0]  lp_r, lp_nxt;
  logic [lakc_pkg::KEY_AW-1:0] ki_r, ki_nxt;

  // Read stage: holds one item while its key symbol comes out of the RAM.
  lakc_pkg::s1_t               s1_r, s1_nxt;
  logic                        s1_valid_r, s1_valid_nxt;

  // Result queue.
  lakc_pkg::result_t           q_mem_r [lakc_pkg::QDEPTH];
  logic [lakc_pkg::QPTR_W-1:0] q_wptr_r, q_rptr_r;
  logic [lakc_pkg::QCNT_W-1:0] q_count_r;

  logic                        in_accept, q_push, q_pop;
  logic [lakc_pkg::SYM_W:0]    sym_bad;
  logic [lakc_pkg::LEN_W-1:0]  kl_eff, ki_inc, lp_inc;
  logic [lakc_pkg::QCNT_W:0]   occupancy;

  logic [lakc_pkg::SYM_W-1:0]  rdata0, rdata1, rdata_sel, shift, res6, wr_data;
  logic                        we0, we1;
  lakc_pkg::result_t           s1_result;

  // Always ready; the user must write the configuration only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  // The read stage always moves on, so the input stalls once the queue could not take
  // everything already in flight.
  assign occupancy = {1'b0, q_count_r} + {{lakc_pkg::QCNT_W{1'b0}}, s1_valid_r};
  assign in_stall  = (occupancy >= (lakc_pkg::QCNT_W + 1)'(lakc_pkg::QDEPTH));
  assign in_accept = in_valid && !in_stall;

  assign sym_bad = lakc_pkg::to_symbol(in_char_code);
  assign kl_eff  = loading_r ? kl_r : '0;
  assign ki_inc  = lakc_pkg::LEN_W'(ki_r) + lakc_pkg::LEN_W'(1);
  assign lp_inc  = lp_r + lakc_pkg::LEN_W'(1);

  // Transfer stage: update the control state and issue the key read for text symbols.
  always_comb begin
    sel_nxt          = sel_r;
    loading_nxt      = loading_r;
    kl_nxt           = kl_r;
    lp_nxt           = lp_r;
    ki_nxt           = ki_r;
    s1_valid_nxt     = 1'b0;
    s1_nxt.is_text   = 1'b0;
    s1_nxt.is_empty  = 1'b0;
    s1_nxt.sym       = sym_bad[lakc_pkg::SYM_W-1:0];
    s1_nxt.eol       = in_end_of_line;
    s1_nxt.bad       = sym_bad[lakc_pkg::SYM_W];
    s1_nxt.ovf       = 1'b0;
    s1_nxt.wr_en     = 1'b0;
    s1_nxt.wr_bank   = sel_r;
    s1_nxt.wr_addr   = ki_r;
    s1_nxt.rd_bank   = sel_r;
    s1_nxt.key_zero  = (kl_r == '0);
    // The previous item writes the RAM in this cycle; the read issued now would miss it.
    s1_nxt.fwd_hit   = s1_valid_r && s1_r.wr_en && (s1_r.wr_bank == sel_r) &&
                       (s1_r.wr_addr == ki_r);
    s1_nxt.fwd_data  = wr_data;

    if (in_accept) begin
      unique case (lakc_pkg::req_t'(in_req_type))
        lakc_pkg::REQ_KEY: begin
          // A key symbol outside a key load starts a new key and drops a partial line.
          s1_valid_nxt = 1'b1;
          loading_nxt  = !in_end_of_line;
          lp_nxt       = '0;
          ki_nxt       = '0;
          kl_nxt       = kl_eff;
          if (kl_eff < lakc_pkg::LEN_W'(lakc_pkg::MAX_LINE)) begin
            s1_nxt.wr_en   = 1'b1;
            s1_nxt.wr_bank = sel_r;
            s1_nxt.wr_addr = kl_eff[lakc_pkg::KEY_AW-1:0];
            kl_nxt         = kl_eff + lakc_pkg::LEN_W'(1);
          end else begin
            s1_nxt.ovf = 1'b1;
          end
        end
        lakc_pkg::REQ_TEXT: begin
          s1_valid_nxt   = 1'b1;
          loading_nxt    = 1'b0;
          s1_nxt.is_text = 1'b1;
          lp_nxt         = lp_r;
          if (lp_r < lakc_pkg::LEN_W'(lakc_pkg::MAX_LINE)) begin
            s1_nxt.wr_en   = 1'b1;
            s1_nxt.wr_bank = ~sel_r;
            s1_nxt.wr_addr = lp_r[lakc_pkg::KEY_AW-1:0];
            lp_nxt         = lp_inc;
          end else begin
            s1_nxt.ovf = 1'b1;
          end
          if (kl_r != '0) begin
            ki_nxt = (ki_inc >= kl_r) ? '0 : ki_inc[lakc_pkg::KEY_AW-1:0];
          end
          if (in_end_of_line) begin
            // The line just collected becomes the key for the next line.
            sel_nxt = ~sel_r;
            kl_nxt  = lp_nxt;
            lp_nxt  = '0;
            ki_nxt  = '0;
          end
        end
        lakc_pkg::REQ_EMPTY: begin
          s1_valid_nxt    = 1'b1;
          loading_nxt     = 1'b0;
          s1_nxt.is_empty = 1'b1;
          s1_nxt.eol      = 1'b1;
          s1_nxt.bad      = 1'b0;
          sel_nxt         = ~sel_r;
          kl_nxt          = lp_r;
          lp_nxt          = '0;
          ki_nxt          = '0;
        end
        lakc_pkg::REQ_NONE: begin
          // Unused request type: taken and dropped without a result.
          s1_valid_nxt = 1'b0;
        end
        default: begin
          s1_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  // Read stage: shift by the key symbol, form the result and write the store.
  always_comb begin
    rdata_sel = s1_r.rd_bank ? rdata1 : rdata0;
    if (s1_r.key_zero) begin
      shift = '0;
    end else if (s1_r.fwd_hit) begin
      shift = s1_r.fwd_data;
    end else begin
      shift = rdata_sel;
    end
    res6    = decrypt_r ? (s1_r.sym - shift) : (s1_r.sym + shift);
    // The plaintext goes into the next key: the result when decrypting, else the input.
    wr_data = (s1_r.is_text && decrypt_r) ? res6 : s1_r.sym;

    s1_result.out_char = s1_r.is_empty ? 8'h00 :
                         lakc_pkg::to_char(s1_r.is_text ? res6 : s1_r.sym);
    s1_result.last     = s1_r.eol;
    s1_result.bad      = s1_r.bad;
    s1_result.ovf      = s1_r.ovf;
  end

  assign we0 = s1_valid_r && s1_r.wr_en && !s1_r.wr_bank;
  assign we1 = s1_valid_r && s1_r.wr_en &&  s1_r.wr_bank;

  lakc_ram #(
    .WIDTH (lakc_pkg::SYM_W),
    .DEPTH (lakc_pkg::MAX_LINE)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (s1_r.wr_addr),
    .wdata (wr_data),
    .raddr (ki_r),
    .rdata (rdata0)
  );

  lakc_ram #(
    .WIDTH (lakc_pkg::SYM_W),
    .DEPTH (lakc_pkg::MAX_LINE)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (s1_r.wr_addr),
    .wdata (wr_data),
    .raddr (ki_r),
    .rdata (rdata1)
  );

  // Result queue: every item is pushed in the cycle in which it sits in the read stage.
  assign q_push = s1_valid_r;
  assign q_pop  = out_valid && !out_stall;

  assign out_valid         = (q_count_r != '0);
  assign out_out_char      = q_mem_r[q_rptr_r].out_char;
  assign out_last_in_line  = q_mem_r[q_rptr_r].last;
  assign out_bad_symbol    = q_mem_r[q_rptr_r].bad;
  assign out_line_overflow = q_mem_r[q_rptr_r].ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r  <= 1'b0;
      sel_r      <= 1'b0;
      loading_r  <= 1'b0;
      kl_r       <= '0;
      lp_r       <= '0;
      ki_r       <= '0;
      s1_valid_r <= 1'b0;
      q_wptr_r   <= '0;
      q_rptr_r   <= '0;
      q_count_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        decrypt_r <= cfg_decrypt_mode;
      end
      sel_r      <= sel_nxt;
      loading_r  <= loading_nxt;
      kl_r       <= kl_nxt;
      lp_r       <= lp_nxt;
      ki_r       <= ki_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (q_push) begin
        q_wptr_r <= (q_wptr_r == lakc_pkg::QPTR_W'(lakc_pkg::QDEPTH - 1)) ?
                    '0 : q_wptr_r + lakc_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        q_rptr_r <= (q_rptr_r == lakc_pkg::QPTR_W'(lakc_pkg::QDEPTH - 1)) ?
                    '0 : q_rptr_r + lakc_pkg::QPTR_W'(1);
      end
      if (q_push && !q_pop) begin
        q_count_r <= q_count_r + lakc_pkg::QCNT_W'(1);
      end else if (q_pop && !q_push) begin
        q_count_r <= q_count_r - lakc_pkg::QCNT_W'(1);
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (q_push) begin
      q_mem_r[q_wptr_r] <= s1_result;
    end
  end

  `LAKC_ASSERT_NEVER(a_queue_no_overrun,
    q_push && !q_pop && (q_count_r == lakc_pkg::QCNT_W'(lakc_pkg::QDEPTH)),
    "result queue overrun")
  `LAKC_ASSERT_IMPLY(a_key_index_in_range, kl_r != '0,
    lakc_pkg::LEN_W'(ki_r) < kl_r, "key index not below key length")
  `LAKC_ASSERT_NEVER(a_line_pos_in_range,
    (lp_r > lakc_pkg::LEN_W'(lakc_pkg::MAX_LINE)) ||
    (kl_r > lakc_pkg::LEN_W'(lakc_pkg::MAX_LINE)), "line counters beyond store depth")
  `LAKC_ASSERT_IMPLY(a_forward_source, s1_valid_r && s1_r.fwd_hit,
    $past(s1_valid_r) && $past(s1_r.wr_en), "forward without a write one cycle before")

endmodule
